FILE: sv/crik_pkg.sv
// Package for the cable robot inverse kinematics core.
// Widths, register indexes and pipeline sizes; no dependencies.
`default_nettype none
package crik_pkg;
  localparam int FRAC_BITS = 8;
  localparam int REG_BITS  = 18;
  localparam int POS_BITS  = 20;
  localparam int LEN_BITS  = 22;
  localparam int DIFF_BITS = 21;
  localparam int MAG_BITS  = 20;
  localparam int SQ_BITS   = 40;
  localparam int SUM_BITS  = 42;
  localparam int ROOT_BITS = 21;
  localparam int ROOT_PER_STAGE = 3;
  localparam int ROOT_STAGES = 7;
  localparam int NUM_CABLES = 4;
  localparam int IDX_BITS = 2;
  localparam int IN_DATA_BITS  = 64;
  localparam int OUT_DATA_BITS = 88;

  typedef enum logic [IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_LENGTH = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [SUM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
  } root_state_t;
endpackage
`default_nettype wire

FILE: sv/crik_sqrt_stage.sv
// One stage of the pipelined integer square root: three restoring digits.
// Depends on crik_pkg.
`default_nettype none
module crik_sqrt_stage import crik_pkg::*; (
  input  wire logic        [2:0] pos_i,
  input  root_state_t            st_i,
  output root_state_t            st_o
);
  // pos_i: index of this stage; it handles root bits 3*pos_i+2 down to 3*pos_i, highest first
  always_comb begin
    logic [SUM_BITS-1:0] trial;
    logic [SUM_BITS-1:0] rem;
    logic [ROOT_BITS-1:0] root;
    logic [4:0] bitpos;
    rem  = st_i.rem;
    root = st_i.root;
    for (int k = 0; k < ROOT_PER_STAGE; k++) begin
      bitpos = 5'(int'(pos_i) * ROOT_PER_STAGE + ROOT_PER_STAGE - 1 - k);
      trial = ({21'd0, root} << (bitpos + 5'd1)) | (SUM_BITS'(1) << {bitpos, 1'b0});
      if (rem >= trial) begin
        rem = rem - trial;
        root[bitpos] = 1'b1;
      end
    end
    st_o.rem  = rem;
    st_o.root = root;
  end
endmodule
`default_nettype wire

FILE: sv/cable_robot_inverse_kinematics_core.sv
// Four-cable robot inverse kinematics, fully pipelined.
// Throughput one beat per cycle while the output is not stalled.
// Stages: difference, square, sum, then seven square-root stages of three digits each.
// A stall freezes the whole pipeline; rst_n (sync, active low) clears valids and
// sets the frame registers to 256.
// Depends on crik_pkg and crik_sqrt_stage.
`default_nettype none
module cable_robot_inverse_kinematics_core import crik_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [IDX_BITS-1:0]      cfg_index,
  input  wire logic [REG_BITS-1:0]      cfg_data,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [IN_DATA_BITS-1:0]  in_tdata,   // pos_x, pos_y, pos_z
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0]      out_tdata   // cable_one..cable_four
);
  localparam int NST = 3 + ROOT_STAGES;

  logic [REG_BITS-1:0] w_r, l_r, h_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= REG_BITS'(256); l_r <= REG_BITS'(256); h_r <= REG_BITS'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  w_r <= cfg_data;
        REG_FRAME_LENGTH: l_r <= cfg_data;
        REG_FRAME_HEIGHT: h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [NST-1:0] vld_r;
  logic adv;
  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign out_tvalid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NST-2:0], in_tvalid};
  end

  // stage 0: magnitudes of differences
  logic signed [POS_BITS-1:0] px, py, pz;
  assign px = in_tdata[19:0];
  assign py = in_tdata[39:20];
  assign pz = in_tdata[59:40];

  function automatic logic [MAG_BITS:0] absd(input logic signed [DIFF_BITS-1:0] d);
    logic [DIFF_BITS-1:0] u;
    u = d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
    return u;
  endfunction

  logic [MAG_BITS:0] ax0_r, ax1_r, ay0_r, ay1_r, az_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ax0_r <= absd(DIFF_BITS'(px) - $signed({3'b0, w_r}));
      ax1_r <= absd(DIFF_BITS'(px));
      ay0_r <= absd(DIFF_BITS'(py) - $signed({3'b0, l_r}));
      ay1_r <= absd(DIFF_BITS'(py));
      az_r  <= absd(DIFF_BITS'(pz) - $signed({3'b0, h_r}));
    end
  end

  // stage 1: squares
  logic [SQ_BITS+1:0] sx0_r, sx1_r, sy0_r, sy1_r, sz_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sx0_r <= ax0_r * ax0_r; sx1_r <= ax1_r * ax1_r;
      sy0_r <= ay0_r * ay0_r; sy1_r <= ay1_r * ay1_r;
      sz_r  <= az_r * az_r;
    end
  end

  // stage 2: sums
  root_state_t st_r [ROOT_STAGES+1][NUM_CABLES];
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0][0] <= '{rem: SUM_BITS'(sx0_r + sy0_r + sz_r), root: '0};
      st_r[0][1] <= '{rem: SUM_BITS'(sx1_r + sy0_r + sz_r), root: '0};
      st_r[0][2] <= '{rem: SUM_BITS'(sx1_r + sy1_r + sz_r), root: '0};
      st_r[0][3] <= '{rem: SUM_BITS'(sx0_r + sy1_r + sz_r), root: '0};
    end
  end

  // root stages, highest digits first
  for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_st
    for (genvar c = 0; c < NUM_CABLES; c++) begin : g_c
      root_state_t nxt;
      crik_sqrt_stage u_stage (
        .pos_i(3'(ROOT_STAGES - 1 - s)),
        .st_i (st_r[s][c]),
        .st_o (nxt)
      );
      always_ff @(posedge clk) begin
        if (adv) st_r[s+1][c] <= nxt;
      end
    end
  end

  assign out_tdata = {LEN_BITS'(st_r[ROOT_STAGES][3].root), LEN_BITS'(st_r[ROOT_STAGES][2].root),
                      LEN_BITS'(st_r[ROOT_STAGES][1].root), LEN_BITS'(st_r[ROOT_STAGES][0].root)};

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("ready");
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0]) else $error("valid");
`endif
endmodule
`default_nettype wire
